[sv/dir_entry_stream_parser_unit_assert.svh]
// Assertion macros for the directory entry stream parser.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef DIR_ENTRY_STREAM_PARSER_UNIT_ASSERT_SVH
`define DIR_ENTRY_STREAM_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DESP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DESP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/desp_pkg.sv]
// Shared types, constants and helpers of the directory entry stream parser.
// No dependencies.
`default_nettype none

package desp_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TRUNC = 2'd1;
  localparam logic [1:0] ERR_BAD   = 2'd2;

  localparam int unsigned MAX_ITEMS = 5;
  localparam int unsigned CNT_W     = 3;

  localparam logic [15:0] HDR_BYTES    = 16'd8;
  localparam logic [15:0] NAME_LEN_POS = 16'd6;
  localparam logic [15:0] PAD_POS      = 16'd7;
  localparam logic [15:0] INODE_BYTES  = 16'd4;
  localparam logic [7:0]  PRINT_LO     = 8'd32;
  localparam logic [7:0]  PRINT_HI     = 8'd126;
  localparam logic [7:0]  BACKSLASH    = 8'h5C;
  localparam logic [7:0]  CHAR_X       = 8'h78;
  localparam logic [15:0] BLOCK_LEN_RESET = 16'd1024;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } item_t;

  // Everything one byte produces, up to MAX_ITEMS items.
  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    item_t [MAX_ITEMS-1:0]      items;
    logic [31:0]                inode;
    logic [1:0]                 err_code;
    logic [15:0]                err_off;
  } bundle_t;

  // Lowercase hex digit for a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_digit = 8'h30 + {4'b0, nib};
    end else begin
      hex_digit = 8'h57 + {4'b0, nib};
    end
  endfunction

endpackage

`default_nettype wire

[sv/desp_parser.sv]
// Record parser: header assembly, checks and name escaping, one byte per cycle while step_i is high.
// Depends on desp_pkg.
`default_nettype none

module desp_parser import desp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,       // byte accepted this cycle
  input  wire logic [7:0]  byte_i,
  input  wire logic [15:0] block_len_i,
  output bundle_t          bundle_o,
  output logic             err_seen_o
);

  logic [15:0] off_q, off_d;
  logic [15:0] rs_q, rs_d;
  logic [31:0] ino_q, ino_d;
  logic [15:0] rl_q, rl_d;
  logic [7:0]  nl_q, nl_d;
  logic        err_q, err_d;

  always_comb begin
    logic [15:0] pos;
    logic [16:0] avail;
    logic        active;
    logic        trunc;
    logic        bad;
    logic        live;
    logic [31:0] ino_base;
    logic [15:0] rl_base;
    logic [CNT_W-1:0] n;
    bundle_t     bun;

    off_d = off_q;
    rs_d  = rs_q;
    ino_d = ino_q;
    rl_d  = rl_q;
    nl_d  = nl_q;
    err_d = err_q;
    bun   = '0;
    n     = '0;

    pos    = off_q - rs_q;
    avail  = {1'b0, block_len_i} - {1'b0, rs_q};
    active = !err_q && (off_q < block_len_i);
    trunc  = !avail[16] && (avail < {1'b0, HDR_BYTES});
    bad    = (rl_q < HDR_BYTES) ||
             (!avail[16] && ({1'b0, rl_q} > avail)) ||
             ({8'b0, byte_i} > (rl_q - HDR_BYTES));
    live   = (ino_q != '0);
    ino_base = (pos == '0) ? '0 : ino_q;
    rl_base  = (pos == '0) ? '0 : rl_q;

    if (active) begin
      if (pos == '0 && trunc) begin
        err_d        = 1'b1;
        bun.cnt      = CNT_W'(1);
        bun.items[0] = '{kind: KIND_ERROR, ch: 8'h00};
        bun.err_code = ERR_TRUNC;
        bun.err_off  = rs_q;
      end else if (pos == NAME_LEN_POS && bad) begin
        err_d        = 1'b1;
        bun.cnt      = CNT_W'(1);
        bun.items[0] = '{kind: KIND_ERROR, ch: 8'h00};
        bun.err_code = ERR_BAD;
        bun.err_off  = rs_q;
      end else begin
        if (pos == '0) begin
          nl_d = '0;
        end
        ino_d = ino_base;
        rl_d  = rl_base;
        if (pos < INODE_BYTES) begin
          ino_d = ino_base | ({24'b0, byte_i} << {pos[1:0], 3'b000});
        end else if (pos < NAME_LEN_POS) begin
          rl_d = rl_base | ({8'b0, byte_i} << {pos[0], 3'b000});
        end else if (pos == NAME_LEN_POS) begin
          nl_d = byte_i;
          if (live) begin
            bun.cnt      = CNT_W'(1);
            bun.items[0] = '{kind: KIND_START, ch: 8'h00};
            bun.inode    = ino_q;
          end
        end else if (pos == PAD_POS) begin
          if (live && nl_q == '0) begin
            bun.cnt      = CNT_W'(1);
            bun.items[0] = '{kind: KIND_END, ch: 8'h00};
          end
        end else if ({1'b0, pos} < ({1'b0, HDR_BYTES} + {9'b0, nl_q})) begin
          if (live) begin
            // Escape the name byte.
            if (byte_i >= PRINT_LO && byte_i <= PRINT_HI && byte_i != BACKSLASH) begin
              bun.items[0] = '{kind: KIND_CHAR, ch: byte_i};
              n = CNT_W'(1);
            end else if (byte_i == BACKSLASH) begin
              bun.items[0] = '{kind: KIND_CHAR, ch: BACKSLASH};
              bun.items[1] = '{kind: KIND_CHAR, ch: BACKSLASH};
              n = CNT_W'(2);
            end else begin
              bun.items[0] = '{kind: KIND_CHAR, ch: BACKSLASH};
              bun.items[1] = '{kind: KIND_CHAR, ch: CHAR_X};
              bun.items[2] = '{kind: KIND_CHAR, ch: hex_digit(byte_i[7:4])};
              bun.items[3] = '{kind: KIND_CHAR, ch: hex_digit(byte_i[3:0])};
              n = CNT_W'(4);
            end
            // Close the entry on its last name byte.
            if ({1'b0, pos} == ({1'b0, PAD_POS} + {9'b0, nl_q})) begin
              bun.items[n] = '{kind: KIND_END, ch: 8'h00};
              n = n + CNT_W'(1);
            end
            bun.cnt = n;
          end
        end
        off_d = off_q + 16'd1;
        if (pos >= PAD_POS && ({1'b0, pos} + 17'd1) == {1'b0, rl_q}) begin
          rs_d = off_q + 16'd1;
        end
      end
    end
    bundle_o = bun;
  end

  assign err_seen_o = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      rs_q  <= '0;
      ino_q <= '0;
      rl_q  <= '0;
      nl_q  <= '0;
      err_q <= 1'b0;
    end else if (step_i) begin
      off_q <= off_d;
      rs_q  <= rs_d;
      ino_q <= ino_d;
      rl_q  <= rl_d;
      nl_q  <= nl_d;
      err_q <= err_d;
    end
  end

endmodule

`default_nettype wire

[sv/desp_emitter.sv]
// Result register: holds one byte's items and hands them out one per cycle while m_tready_i is high.
// Depends on desp_pkg.
`default_nettype none

module desp_emitter import desp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire bundle_t     bundle_i,
  output logic             take_o,       // room for a new bundle this cycle
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [63:0]      m_tdata_o,
  output logic [1:0]       m_tuser_o,
  output logic             m_tlast_o
);

  bundle_t          bun_q;
  logic [CNT_W-1:0] idx_q;
  logic             vld_q;
  logic             last;
  item_t            cur;

  assign cur  = bun_q.items[idx_q];
  assign last = (idx_q == (bun_q.cnt - CNT_W'(1)));

  assign take_o     = !vld_q || (m_tready_i && last);
  assign m_tvalid_o = vld_q;
  assign m_tuser_o  = cur.kind;
  assign m_tlast_o  = last;
  assign m_tdata_o  = {
    6'b0,
    (cur.kind == KIND_ERROR) ? bun_q.err_off  : 16'h0000,
    (cur.kind == KIND_ERROR) ? bun_q.err_code : ERR_NONE,
    (cur.kind == KIND_CHAR)  ? cur.ch         : 8'h00,
    (cur.kind == KIND_START) ? bun_q.inode    : 32'h0
  };

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bun_q <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (vld_q && m_tready_i) begin
      if (last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/dir_entry_stream_parser_unit.sv]
// Top level of the directory entry stream parser: config register, parser, result register.
// Depends on desp_pkg, desp_parser, desp_emitter and the assertion macro header.
`default_nettype none

// Takes a directory block (on-disk ext2 record layout) one byte per item on the slave
// stream and writes result items on the master stream: an entry start carrying the
// inode, the escaped name characters, an entry end, or a sticky error (truncated
// header or bad record) with the offset of the failing record. Dead entries and padding
// produce nothing. cfg_we_i loads block_length (reset 1024); write it only while idle.
// Rate: bytes stream at one per cycle while each makes zero or one item and the master
// side is ready; a byte that makes several items (up to 5: an escaped name byte plus the
// entry end) holds the slave side until they drain, since the result register hands out
// one item a cycle while m_axis_tready_i is high. tlast marks the final item caused by
// a byte. s_axis_tready_o stays low while the earlier items of a byte drain and follows
// m_axis_tready_i combinationally while the last item of a byte waits on the master side.

module dir_entry_stream_parser_unit import desp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,     // block_length
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] byte_value
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [31:0] inode_number, [39:32] out_char, [41:40] error_code,
  // [57:42] error_offset, [63:58] zero
  output logic [63:0]      m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o,  // [1:0] result_kind
  output logic             m_axis_tlast_o   // last_of_run
);

  logic [15:0] block_len_q;
  logic        take;
  logic        accept;
  logic        load;
  logic        err_seen;
  bundle_t     bundle;

  // Block length register; new value applies to the next byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_len_q <= BLOCK_LEN_RESET;
    end else if (cfg_we_i) begin
      block_len_q <= cfg_wdata_i;
    end
  end

  // Accept a byte whenever the result register is free or drains its last item now.
  assign s_axis_tready_o = take;
  assign accept          = s_axis_tvalid_i && take;
  // Only bytes that produce items occupy the result register.
  assign load            = accept && (bundle.cnt != '0);

  desp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .byte_i      (s_axis_tdata_i),
    .block_len_i (block_len_q),
    .bundle_o    (bundle),
    .err_seen_o  (err_seen)
  );

  desp_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .bundle_i   (bundle),
    .take_o     (take),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

`include "dir_entry_stream_parser_unit_assert.svh"

  // Once an error is latched the parser must stay silent.
`DESP_ASSERT_NOW(a_silent_after_error, err_seen, bundle.cnt == '0, "items after sticky error")
  // An error item is always the only and final item of its byte.
`DESP_ASSERT_NOW(a_error_is_last, m_axis_tvalid_o && m_axis_tuser_o == KIND_ERROR,
  m_axis_tlast_o, "error item not last of run")
  // A byte that produces items shows its first item in the next cycle.
`DESP_ASSERT_NEXT(a_load_shows, load, m_axis_tvalid_o, "loaded items not presented")

endmodule

`default_nettype wire

[sim/dir_listing_checker.sv]
`timescale 1ns / 100ps
// Listing checker for the directory entry stream parser: watches the config port and both
// streams, predicts the result items of every accepted byte and compares them in order.
// Depends on desp_pkg for the result kinds, error codes and format constants.

module dir_listing_checker import desp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [7:0]  s_tdata_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [63:0] m_tdata_i,
  input  wire logic [1:0]  m_tuser_i,
  input  wire logic        m_tlast_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] inode;
    logic [7:0]  ch;
    logic [1:0]  code;
    logic [15:0] offs;
    logic        last;
  } listing_item_t;

  listing_item_t expected_listing [$];
  listing_item_t burst [MAX_ITEMS];
  int unsigned   burst_n;

  // Parser state as the block should hold it.
  logic [15:0] blk_len;
  logic [15:0] offset;
  logic [15:0] rec_start;
  logic [15:0] rec_len;
  logic [31:0] inode_acc;
  logic [7:0]  nm_len;
  logic        err_seen;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PRINT_CAP) begin
      $display("%0t: listing mismatch: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  function automatic listing_item_t mk_item(input kind_e ki, input logic [31:0] ino,
                                            input logic [7:0] chr, input logic [1:0] ec,
                                            input logic [15:0] eo);
    mk_item = '{kind: ki, inode: ino, ch: chr, code: ec, offs: eo, last: 1'b0};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = "0" + {4'd0, nib};
    end else begin
      hex_char = "a" + {4'd0, nib} - 8'd10;
    end
  endfunction

  task automatic stage(input listing_item_t it);
    burst[burst_n] = it;
    burst_n++;
  endtask

  task automatic stage_char(input logic [7:0] c);
    stage(mk_item(KIND_CHAR, 32'd0, c, ERR_NONE, 16'd0));
  endtask

  // Escape one name byte: printable passes, backslash doubles, the rest becomes \xhh.
  task automatic stage_name_byte(input logic [7:0] b);
    if (b >= PRINT_LO && b <= PRINT_HI && b != BACKSLASH) begin
      stage_char(b);
    end else if (b == BACKSLASH) begin
      stage_char(BACKSLASH);
      stage_char(BACKSLASH);
    end else begin
      stage_char(BACKSLASH);
      stage_char(CHAR_X);
      stage_char(hex_char(b[7:4]));
      stage_char(hex_char(b[3:0]));
    end
  endtask

  task automatic raise_error(input logic [1:0] code);
    listing_item_t it;
    it = mk_item(KIND_ERROR, 32'd0, 8'd0, code, rec_start);
    it.last = 1'b1;
    err_seen = 1'b1;
    expected_listing.push_back(it);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] pos;
    logic [31:0] room;
    burst_n = 0;
    if (err_seen || offset >= blk_len) return;
    pos = offset - rec_start;
    room = {16'd0, blk_len} - {16'd0, rec_start};
    if (pos == 16'd0) begin
      if (room < 32'(HDR_BYTES)) begin
        raise_error(ERR_TRUNC);
        return;
      end
      inode_acc = '0;
      rec_len = '0;
      nm_len = '0;
    end
    if (pos < INODE_BYTES) begin
      inode_acc = inode_acc | ({24'd0, b} << (8 * pos));
    end else if (pos < NAME_LEN_POS) begin
      rec_len = rec_len | ({8'd0, b} << (8 * (pos - INODE_BYTES)));
    end else if (pos == NAME_LEN_POS) begin
      nm_len = b;
      if (rec_len < HDR_BYTES || {16'd0, rec_len} > room ||
          {24'd0, nm_len} > {16'd0, rec_len} - 32'(HDR_BYTES)) begin
        raise_error(ERR_BAD);
        return;
      end
      if (inode_acc != 32'd0) stage(mk_item(KIND_START, inode_acc, 8'd0, ERR_NONE, 16'd0));
    end else if (pos == PAD_POS) begin
      if (inode_acc != 32'd0 && nm_len == 8'd0) begin
        stage(mk_item(KIND_END, 32'd0, 8'd0, ERR_NONE, 16'd0));
      end
    end else if ({16'd0, pos} < 32'(HDR_BYTES) + {24'd0, nm_len}) begin
      if (inode_acc != 32'd0) begin
        stage_name_byte(b);
        if ({16'd0, pos} == 32'(PAD_POS) + {24'd0, nm_len}) begin
          stage(mk_item(KIND_END, 32'd0, 8'd0, ERR_NONE, 16'd0));
        end
      end
    end
    offset = offset + 16'd1;
    if (pos >= PAD_POS && {16'd0, pos} + 32'd1 == {16'd0, rec_len}) rec_start = offset;
    if (burst_n > 0) burst[burst_n-1].last = 1'b1;
    for (int i = 0; i < burst_n; i++) expected_listing.push_back(burst[i]);
  endtask

  task automatic check_result();
    listing_item_t want;
    if (expected_listing.size() == 0) begin
      report_mismatch($sformatf("unexpected item kind %0d tdata %h", m_tuser_i, m_tdata_i));
      return;
    end
    want = expected_listing.pop_front();
    if (m_tuser_i != want.kind) begin
      report_mismatch($sformatf("kind %0d, want %0d", m_tuser_i, want.kind));
    end
    if (m_tdata_i[31:0] != want.inode) begin
      report_mismatch($sformatf("inode %h, want %h", m_tdata_i[31:0], want.inode));
    end
    if (m_tdata_i[39:32] != want.ch) begin
      report_mismatch($sformatf("char %h, want %h", m_tdata_i[39:32], want.ch));
    end
    if (m_tdata_i[41:40] != want.code) begin
      report_mismatch($sformatf("error code %0d, want %0d", m_tdata_i[41:40], want.code));
    end
    if (m_tdata_i[57:42] != want.offs) begin
      report_mismatch($sformatf("error offset %0d, want %0d", m_tdata_i[57:42], want.offs));
    end
    if (m_tdata_i[63:58] != 6'd0) begin
      report_mismatch($sformatf("pad bits %h not zero", m_tdata_i[63:58]));
    end
    if (m_tlast_i != want.last) begin
      report_mismatch($sformatf("tlast %0b, want %0b", m_tlast_i, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_len = BLOCK_LEN_RESET;
      offset = '0;
      rec_start = '0;
      rec_len = '0;
      inode_acc = '0;
      nm_len = '0;
      err_seen = 1'b0;
      expected_listing.delete();
      fail_count_o = 0;
    end else begin
      // A byte taken at this edge still sees the old block length.
      if (s_tvalid_i && s_tready_i) parse_byte(s_tdata_i);
      if (cfg_we_i) blk_len = cfg_wdata_i;
      if (m_tvalid_i && m_tready_i) check_result();
    end
    pending_o = expected_listing.size();
  end

endmodule

[sim/tb_dir_entry_stream_parser_unit.sv]
`timescale 1ns / 100ps
// Top of the directory entry stream parser testbench: clock, reset, byte stimulus, sink.
// Depends on desp_pkg, dir_entry_stream_parser_unit and dir_listing_checker.

module tb_dir_entry_stream_parser_unit;
  import desp_pkg::*;

  // Receiver hold-off that fills the block and stalls its input.
  localparam int unsigned LONG_HOLD      = 200;
  // Cycles with no handshake of any kind before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Settle time after the last expected result, for bytes that make no result.
  localparam int unsigned QUIET_CYCLES   = 8;
  localparam int unsigned RANDOM_BYTES   = 450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int unsigned fails;
  int unsigned pending;
  int unsigned hold_asks = 0;
  int unsigned idle_cycles = 0;
  bit          src_busy = 1'b0;
  logic [15:0] blk_end = '0;
  logic [7:0]  dir_bytes [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dir_entry_stream_parser_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  dir_listing_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // Watchdog: count cycles in which no item moves on any port; give up at the limit.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_dir_entry_stream_parser_unit: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink. Alternate calm stretches (always ready) with busy ones (random short
  // stalls, now and then a long one). A new hold request forces one long hold-off.
  initial begin : sink
    int unsigned hold_left;
    int unsigned hold_seen;
    int unsigned span_left;
    bit          busy;
    hold_left = 0;
    hold_seen = 0;
    span_left = 0;
    busy = 1'b0;
    forever begin
      @(negedge clk);
      if (span_left == 0) begin
        busy = ($urandom_range(0, 2) != 0);
        span_left = $urandom_range(20, 120);
      end
      span_left--;
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && busy && $urandom_range(0, 3) == 0) begin
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one byte from a falling edge, hold it until accepted, then maybe leave a gap.
  // Valid stays high straight into the next byte when there is no gap.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    s_tdata <= b;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    gap = 0;
    if (src_busy && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every expected item has come back, then settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_block_length(input logic [15:0] len);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Record header: inode and record length little-endian, name length, one spare byte.
  task automatic add_header(input logic [31:0] ino, input logic [15:0] rlen,
                            input logic [7:0] nlen);
    for (int i = 0; i < 4; i++) dir_bytes.push_back(ino[8*i +: 8]);
    dir_bytes.push_back(rlen[7:0]);
    dir_bytes.push_back(rlen[15:8]);
    dir_bytes.push_back(nlen);
    dir_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Name byte of a given flavor: plain text, anything, or escape-heavy.
  function automatic logic [7:0] pick_name_byte(input int unsigned flavor);
    case (flavor)
      0: pick_name_byte = 8'($urandom_range(32, 126));
      1: pick_name_byte = 8'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 2))
          0: pick_name_byte = BACKSLASH;
          1: pick_name_byte = 8'($urandom_range(0, 31));
          default: pick_name_byte = 8'($urandom_range(127, 255));
        endcase
      end
    endcase
  endfunction

  task automatic add_record(input logic [31:0] ino, input logic [7:0] nlen,
                            input int unsigned pad, input int unsigned flavor);
    add_header(ino, 16'(HDR_BYTES + nlen + pad), nlen);
    for (int i = 0; i < nlen; i++) dir_bytes.push_back(pick_name_byte(flavor));
    for (int i = 0; i < pad; i++) dir_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_record();
    logic [31:0] ino;
    logic [7:0]  nlen;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) ino = 32'd0;
    else if (pick < 15) ino = 32'hFFFF_FFFF;
    else ino = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 15) nlen = 8'd0;
    else if (pick < 17) nlen = 8'($urandom_range(200, 255));
    else nlen = 8'($urandom_range(1, 12));
    add_record(ino, nlen, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7),
               $urandom_range(0, 2));
  endtask

  // Extend the block by the staged records, stream them, add a few ignored bytes past
  // the end, then drain so the next register write lands on an idle block.
  task automatic run_segment();
    blk_end = blk_end + 16'(dir_bytes.size());
    write_block_length(blk_end);
    foreach (dir_bytes[i]) push_byte(dir_bytes[i]);
    dir_bytes.delete();
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned flaw;
    logic [15:0] rlen;
    sent = 0;
    phase = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty block: both bytes fall past the end and are dropped.
    write_block_length(16'd0);
    push_byte(8'hA5);
    push_byte(8'h5A);
    wait_idle();

    // Directed block: max inode with every escape class, a dead entry, an empty name.
    add_header(32'hFFFF_FFFF, 16'd13, 8'd5);
    dir_bytes.push_back(8'h20);
    dir_bytes.push_back(8'h7E);
    dir_bytes.push_back(BACKSLASH);
    dir_bytes.push_back(8'h00);
    dir_bytes.push_back(8'hFF);
    add_header(32'd0, 16'd8, 8'd0);
    add_header(32'd1, 16'd8, 8'd0);
    run_segment();

    // Random blocks of well-formed records; one phase carries a 255-byte escape-heavy
    // name behind a long receiver hold-off so the block backs up into its input.
    while (sent < RANDOM_BYTES || phase <= 2) begin
      src_busy = ($urandom_range(0, 2) != 0);
      if (phase == 2) begin
        src_busy = 1'b0;
        hold_asks++;
        add_record($urandom, 8'd255, 0, 2);
      end
      repeat ($urandom_range(1, 4)) add_random_record();
      sent += dir_bytes.size();
      run_segment();
      phase++;
    end

    // Final broken record: the error is sticky, so only one kind fits in a run.
    flaw = $urandom_range(0, 3);
    if (flaw == 0) begin
      // Truncated header: fewer than eight bytes left at a record start.
      write_block_length(blk_end + 16'($urandom_range(1, 7)));
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      write_block_length(16'hFFFF);
      if (flaw == 1) begin
        rlen = 16'($urandom_range(0, 7));
        add_header($urandom, rlen, 8'($urandom_range(0, 255)));
      end else if (flaw == 2) begin
        add_header($urandom, 16'hFFFF, 8'd0);
      end else begin
        rlen = 16'($urandom_range(8, 40));
        add_header($urandom, rlen, 8'($urandom_range(rlen - 7, 255)));
      end
      repeat ($urandom_range(1, 6)) dir_bytes.push_back(8'($urandom_range(0, 255)));
      foreach (dir_bytes[i]) push_byte(dir_bytes[i]);
      dir_bytes.delete();
    end
    wait_idle();

    if (fails == 0 && pending == 0) begin
      $display("tb_dir_entry_stream_parser_unit: done, clean");
    end else begin
      $display("tb_dir_entry_stream_parser_unit: done, errors");
    end
    $finish;
  end

endmodule
